// File: src/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the framed command deframer.
// ----------------------------------------------------------------------------
package fcd_pkg;

    // Command store holds one frame, start byte through stop byte
    localparam int CMD_DEPTH = 256;
    localparam int CMD_AW    = 8;

    // Start, id and length in front of the payload, stop byte behind it
    localparam int FRAME_OVERHEAD = 4;
    localparam int LEN_OFFSET     = 2;
    localparam int ID_OFFSET      = 1;
    localparam int STOP_OFFSET    = 3;

    // Configuration register indexes
    localparam logic [7:0] CFG_START_BYTE = 8'd0;
    localparam logic [7:0] CFG_STOP_BYTE  = 8'd1;

    localparam logic [7:0] START_BYTE_RESET = 8'd175;
    localparam logic [7:0] STOP_BYTE_RESET  = 8'd250;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_SRCH,
        ST_SRCH_CHK,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_STOP_RD,
        ST_STOP_CHK,
        ST_COPY,
        ST_RESULT
    } fcd_state_t;

endpackage

// File: src/framed_command_deframer_unit.sv
// ----------------------------------------------------------------------------
// framed_command_deframer_unit
// Start/length/stop byte frame deframer with receive and command stores.
// ----------------------------------------------------------------------------
// Each input word either pushes a received byte (tuser 0) or reads one byte of
// the last accepted command (tuser 1); every input word yields one result word.
// The receive store is a circular buffer in one RAM; after each push a
// sequencer rescans it from the head through the single read port: it reads
// and checks each byte searched for the start byte, then reads and checks the
// length and the stop byte, and copies an accepted frame into the command RAM.
// A push ends without a frame when fewer than four bytes are held from the
// start byte or the frame still waits for payload bytes; each start byte
// dropped for a bad length or stop byte adds a rescan. A stalled result word
// holds the sequencer in its last state. Neither store is cleared after reset,
// so there is no start-up pass; configuration is accepted whenever out of
// reset and should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module framed_command_deframer_unit
    import fcd_pkg::*;
#(
    parameter int BUF_DEPTH   = 256,
    parameter int MAX_PAYLOAD = 128
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte [7:0], read_index [15:8]
    input  logic [0:0]  s_tuser,   // mode [0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cmd_id [7:0], payload_len [15:8],
                                   // read_byte [23:16], dropped [24], zero [31:25]
    output logic [0:0]  m_tuser,   // frame_ready [0]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam int LW = (FW > 9) ? FW : 9;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(BUF_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUF_DEPTH);
    localparam logic [7:0]    MAX_LEN = 8'(MAX_PAYLOAD);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    fcd_state_t      state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   ofs_reg, ofs_next;
    logic [8:0]      k_reg, k_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      start_cfg_reg, stop_cfg_reg;

    logic            res_frame_reg, res_frame_next;
    logic [7:0]      res_id_reg, res_id_next;
    logic [7:0]      res_len_reg, res_len_next;
    logic [7:0]      res_rbyte_reg, res_rbyte_next;
    logic            res_drop_reg, res_drop_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [31:0]     m_tdata_reg;
    logic [0:0]      m_tuser_reg;
    logic            m_load;

    logic            rx_we;
    logic [AW-1:0]   rx_waddr, rx_raddr;
    logic [7:0]      rx_rdata;
    logic            cmd_we;
    logic [CMD_AW-1:0] cmd_waddr;
    logic [7:0]      cmd_wdata, cmd_rdata;

    logic            in_acc;
    logic [LW-1:0]   lenp4;
    logic [LW-1:0]   rdp4;
    logic [FW-1:0]   fill_after;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready = aresetn;
    assign lenp4     = LW'(len_reg) + LW'(FRAME_OVERHEAD);
    assign rdp4      = LW'(rx_rdata) + LW'(FRAME_OVERHEAD);
    assign fill_after = fill_reg - ofs_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    fcd_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (s_tdata[7:0]),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    fcd_ram #(.WIDTH(8), .DEPTH(CMD_DEPTH)) u_cmd_ram (
        .aclk  (aclk),
        .we    (cmd_we),
        .waddr (cmd_waddr),
        .wdata (cmd_wdata),
        .raddr (s_tdata[15:8]),
        .rdata (cmd_rdata)
    );

    // Push lands at the tail in the accept cycle
    assign rx_we    = in_acc && !s_tuser[0] && (fill_reg != DEPTH_F);
    assign rx_waddr = wrap_add(head_reg, fill_reg[AW-1:0]);

    always_comb begin
        unique case (state_reg)
            ST_SRCH:    rx_raddr = wrap_add(head_reg, ofs_reg[AW-1:0]);
            ST_LEN_RD:  rx_raddr = wrap_add(head_reg, AW'(LEN_OFFSET));
            ST_STOP_RD: rx_raddr = wrap_add(head_reg, AW'(len_reg) + AW'(STOP_OFFSET));
            ST_COPY:    rx_raddr = wrap_add(head_reg, AW'(k_reg));
            default:    rx_raddr = head_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        ofs_next       = ofs_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        res_frame_next = res_frame_reg;
        res_id_next    = res_id_reg;
        res_len_next   = res_len_reg;
        res_rbyte_next = res_rbyte_reg;
        res_drop_next  = res_drop_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_load         = 1'b0;
        cmd_we         = 1'b0;
        cmd_waddr      = k_reg[CMD_AW-1:0] - CMD_AW'(1);
        cmd_wdata      = rx_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_frame_next = 1'b0;
                    res_id_next    = 8'd0;
                    res_len_next   = 8'd0;
                    res_rbyte_next = 8'd0;
                    res_drop_next  = 1'b0;
                    if (s_tuser[0]) begin
                        state_next = ST_RD_WAIT;
                    end else begin
                        if (fill_reg == DEPTH_F) begin
                            res_drop_next = 1'b1;
                        end else begin
                            fill_next = fill_reg + FW'(1);
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_RD_WAIT: begin
                res_rbyte_next = cmd_rdata;
                state_next     = ST_RESULT;
            end
            ST_SCAN: begin
                ofs_next = '0;
                if (fill_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
                if (rx_rdata == start_cfg_reg) begin
                    head_next = wrap_add(head_reg, ofs_reg[AW-1:0]);
                    fill_next = fill_after;
                    if (fill_after < FW'(FRAME_OVERHEAD)) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_LEN_RD;
                    end
                end else if (ofs_reg + FW'(1) >= fill_reg) begin
                    // no start byte anywhere: empty the store
                    fill_next  = '0;
                    state_next = ST_RESULT;
                end else begin
                    ofs_next   = ofs_reg + FW'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_LEN_RD: begin
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK: begin
                len_next = rx_rdata;
                if (rx_rdata > MAX_LEN) begin
                    head_next  = wrap_add(head_reg, AW'(1));
                    fill_next  = fill_reg - FW'(1);
                    state_next = ST_SCAN;
                end else if (rdp4 > LW'(fill_reg)) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_STOP_RD;
                end
            end
            ST_STOP_RD: begin
                state_next = ST_STOP_CHK;
            end
            ST_STOP_CHK: begin
                if (rx_rdata != stop_cfg_reg) begin
                    head_next  = wrap_add(head_reg, AW'(1));
                    fill_next  = fill_reg - FW'(1);
                    state_next = ST_SCAN;
                end else begin
                    k_next     = '0;
                    state_next = ST_COPY;
                end
            end
            ST_COPY: begin
                // read byte k, write byte k-1 read in the previous cycle
                if (k_reg != '0) begin
                    cmd_we = 1'b1;
                    if (k_reg == 9'(ID_OFFSET + 1)) begin
                        res_id_next = rx_rdata;
                    end
                end
                if (LW'(k_reg) == lenp4) begin
                    head_next      = wrap_add(head_reg, lenp4[AW-1:0]);
                    fill_next      = fill_reg - lenp4[FW-1:0];
                    res_frame_next = 1'b1;
                    res_len_next   = len_reg;
                    state_next     = ST_RESULT;
                end else begin
                    k_next = k_reg + 9'd1;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_load        = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            start_cfg_reg <= START_BYTE_RESET;
            stop_cfg_reg  <= STOP_BYTE_RESET;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_START_BYTE) begin
                    start_cfg_reg <= cfg_data;
                end else if (cfg_index == CFG_STOP_BYTE) begin
                    stop_cfg_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        ofs_reg       <= ofs_next;
        k_reg         <= k_next;
        len_reg       <= len_next;
        res_frame_reg <= res_frame_next;
        res_id_reg    <= res_id_next;
        res_len_reg   <= res_len_next;
        res_rbyte_reg <= res_rbyte_next;
        res_drop_reg  <= res_drop_next;
        if (m_load) begin
            m_tdata_reg <= {7'd0, res_drop_reg, res_rbyte_reg, res_len_reg, res_id_reg};
            m_tuser_reg <= res_frame_reg;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_F)
        else $error("fill count above store depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < AW'(BUF_DEPTH - 1) || head_reg == AW'(BUF_DEPTH - 1))
        else $error("head pointer outside store");

    a_read_keeps_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tuser[0]) |=> $stable(fill_reg))
        else $error("command read changed the receive store");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !s_tuser[0] && fill_reg == DEPTH_F) |=> res_drop_reg)
        else $error("push into full store not flagged");

    a_copy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (LW'(k_reg) <= lenp4 && LW'(fill_reg) >= lenp4))
        else $error("frame copy past frame end");

endmodule

// File: src/fcd_ram.sv
// ----------------------------------------------------------------------------
// fcd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
